// ----- rtl/rmq_pkg.sv -----
// shared types and constants for the rotation matrix to quaternion unit
package rmq_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int ELEM_W      = 16;
  localparam int RAD_W       = ELEM_W + 2;
  localparam int NUM_W       = ELEM_W + 1;
  localparam int ROOT_W      = (RAD_W - 1 + FRAC_BITS + 1) / 2;
  localparam int SQV_W       = 2 * ROOT_W;
  localparam int SQRT_STAGES = ROOT_W + 1;
  localparam int QUO_W       = ELEM_W;
  localparam int DVD_W       = NUM_W + FRAC_BITS + 1;
  localparam int DVS_W       = ROOT_W + 1;
  localparam int REM_W       = DVS_W + QUO_W;
  localparam int DIV_STAGES  = QUO_W + 1;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    PATH_TRACE,
    PATH_X,
    PATH_Y,
    PATH_Z
  } path_t;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [NUM_W-1:0]  num_t;

  typedef struct packed {
    path_t            path;
    logic             bad;
    logic [RAD_W-2:0] rad;
    num_t             n0;
    num_t             n1;
    num_t             n2;
  } job_t;

  typedef struct packed {
    path_t             path;
    logic              bad;
    logic [ROOT_W-1:0] half;
  } tag_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

// ----- rtl/rmq_front.sv -----
// front end: accepts matrices and picks the branch, radicand and numerators
module rmq_front (
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [9*rmq_pkg::ELEM_W-1:0] s_tdata,
  input  rmq_pkg::qstat_t            qstat,
  output logic                       push,
  output rmq_pkg::job_t              job
);

  rmq_pkg::elem_t                   e [9];
  logic signed [rmq_pkg::RAD_W-1:0] d0, d1, d2, one, tr, rad;

  assign s_tready = !qstat.full;
  assign push     = s_tvalid && !qstat.full;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e[k] = s_tdata[k*rmq_pkg::ELEM_W +: rmq_pkg::ELEM_W];
    end
    d0  = rmq_pkg::RAD_W'(e[0]);
    d1  = rmq_pkg::RAD_W'(e[4]);
    d2  = rmq_pkg::RAD_W'(e[8]);
    one = rmq_pkg::RAD_W'(1) << rmq_pkg::FRAC_BITS;
    tr  = d0 + d1 + d2;
    job = '0;
    if (tr > 0) begin
      job.path = rmq_pkg::PATH_TRACE;
      rad      = tr + one;
      job.n0   = rmq_pkg::NUM_W'(e[5]) - rmq_pkg::NUM_W'(e[7]);
      job.n1   = rmq_pkg::NUM_W'(e[6]) - rmq_pkg::NUM_W'(e[2]);
      job.n2   = rmq_pkg::NUM_W'(e[1]) - rmq_pkg::NUM_W'(e[3]);
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      job.path = rmq_pkg::PATH_X;
      rad      = one + d0 - d1 - d2;
      job.n0   = rmq_pkg::NUM_W'(e[1]) + rmq_pkg::NUM_W'(e[3]);
      job.n1   = rmq_pkg::NUM_W'(e[2]) + rmq_pkg::NUM_W'(e[6]);
      job.n2   = rmq_pkg::NUM_W'(e[5]) - rmq_pkg::NUM_W'(e[7]);
    end else if (e[4] > e[8]) begin
      job.path = rmq_pkg::PATH_Y;
      rad      = one + d1 - d0 - d2;
      job.n0   = rmq_pkg::NUM_W'(e[1]) + rmq_pkg::NUM_W'(e[3]);
      job.n1   = rmq_pkg::NUM_W'(e[5]) + rmq_pkg::NUM_W'(e[7]);
      job.n2   = rmq_pkg::NUM_W'(e[6]) - rmq_pkg::NUM_W'(e[2]);
    end else begin
      job.path = rmq_pkg::PATH_Z;
      rad      = one + d2 - d0 - d1;
      job.n0   = rmq_pkg::NUM_W'(e[2]) + rmq_pkg::NUM_W'(e[6]);
      job.n1   = rmq_pkg::NUM_W'(e[5]) + rmq_pkg::NUM_W'(e[7]);
      job.n2   = rmq_pkg::NUM_W'(e[1]) - rmq_pkg::NUM_W'(e[3]);
    end
    job.bad = (rad <= 0);
    job.rad = rad[rmq_pkg::RAD_W-2:0];
  end

endmodule

// ----- rtl/rmq_queue.sv -----
// short fifo between the front end and the arithmetic back end
module rmq_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rmq_pkg::job_t   wdata,
  input  logic            pop,
  output rmq_pkg::job_t   rdata,
  output rmq_pkg::qstat_t qstat
);

  rmq_pkg::job_t               mem [rmq_pkg::QDEPTH];
  logic [rmq_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [rmq_pkg::QPTR_W:0]    count;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == (rmq_pkg::QPTR_W+1)'(rmq_pkg::QDEPTH));
  assign rdata       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/rmq_sqrt.sv -----
// pipelined integer square root, one root bit per stage
module rmq_sqrt (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [rmq_pkg::RAD_W-2:0]   rad,
  output logic [rmq_pkg::ROOT_W-1:0]  root
);

  logic [rmq_pkg::SQV_W-1:0]  rem_q  [rmq_pkg::SQRT_STAGES];
  logic [rmq_pkg::ROOT_W-1:0] root_q [rmq_pkg::SQRT_STAGES];
  logic [rmq_pkg::SQV_W-1:0]  trial  [rmq_pkg::SQRT_STAGES];

  always_comb begin
    trial[0] = '0;
    for (int k = 1; k < rmq_pkg::SQRT_STAGES; k++) begin
      trial[k] = (rmq_pkg::SQV_W'(root_q[k-1]) << (rmq_pkg::ROOT_W - k + 1))
               + (rmq_pkg::SQV_W'(1) << (2 * (rmq_pkg::ROOT_W - k)));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_q[0]  <= rmq_pkg::SQV_W'({rad, {rmq_pkg::FRAC_BITS{1'b0}}});
      root_q[0] <= '0;
      for (int k = 1; k < rmq_pkg::SQRT_STAGES; k++) begin
        if (rem_q[k-1] >= trial[k]) begin
          rem_q[k]  <= rem_q[k-1] - trial[k];
          root_q[k] <= root_q[k-1] | (rmq_pkg::ROOT_W'(1) << (rmq_pkg::ROOT_W - k));
        end else begin
          rem_q[k]  <= rem_q[k-1];
          root_q[k] <= root_q[k-1];
        end
      end
    end
  end

  assign root = root_q[rmq_pkg::SQRT_STAGES-1];

endmodule

// ----- rtl/rmq_div.sv -----
// pipelined rounding divider n / (2 s), one quotient bit per stage, saturating
module rmq_div (
  input  logic                        clk,
  input  logic                        adv,
  input  rmq_pkg::num_t               num,
  input  logic [rmq_pkg::ROOT_W-1:0]  root,
  output rmq_pkg::elem_t              quo
);

  logic [rmq_pkg::NUM_W-1:0]  mag;
  logic [rmq_pkg::DVD_W-1:0]  dvd;
  logic [rmq_pkg::DVS_W-1:0]  dvs;
  logic [rmq_pkg::REM_W-1:0]  rem_q [rmq_pkg::DIV_STAGES];
  logic [rmq_pkg::DVS_W-1:0]  dvs_q [rmq_pkg::DIV_STAGES];
  logic [rmq_pkg::QUO_W-1:0]  quo_q [rmq_pkg::DIV_STAGES];
  logic                       neg_q [rmq_pkg::DIV_STAGES];
  logic                       ovf_q [rmq_pkg::DIV_STAGES];
  logic [rmq_pkg::REM_W-1:0]  step  [rmq_pkg::DIV_STAGES];
  logic [rmq_pkg::QUO_W-1:0]  ql;

  always_comb begin
    mag = num[rmq_pkg::NUM_W-1] ? rmq_pkg::NUM_W'(-num) : rmq_pkg::NUM_W'(num);
    dvd = (rmq_pkg::DVD_W'(mag) << rmq_pkg::FRAC_BITS) + rmq_pkg::DVD_W'(root);
    dvs = {root, 1'b0};
    step[0] = '0;
    for (int k = 1; k < rmq_pkg::DIV_STAGES; k++) begin
      step[k] = rmq_pkg::REM_W'(dvs_q[k-1]) << (rmq_pkg::QUO_W - k);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_q[0] <= rmq_pkg::REM_W'(dvd);
      dvs_q[0] <= dvs;
      quo_q[0] <= '0;
      neg_q[0] <= num[rmq_pkg::NUM_W-1];
      ovf_q[0] <= rmq_pkg::REM_W'(dvd) >= (rmq_pkg::REM_W'(dvs) << rmq_pkg::QUO_W);
      for (int k = 1; k < rmq_pkg::DIV_STAGES; k++) begin
        dvs_q[k] <= dvs_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        if (rem_q[k-1] >= step[k]) begin
          rem_q[k] <= rem_q[k-1] - step[k];
          quo_q[k] <= quo_q[k-1] | (rmq_pkg::QUO_W'(1) << (rmq_pkg::QUO_W - k));
        end else begin
          rem_q[k] <= rem_q[k-1];
          quo_q[k] <= quo_q[k-1];
        end
      end
    end
  end

  // saturate to the signed output range
  always_comb begin
    ql = quo_q[rmq_pkg::DIV_STAGES-1];
    if (neg_q[rmq_pkg::DIV_STAGES-1]) begin
      if (ovf_q[rmq_pkg::DIV_STAGES-1] || (ql[rmq_pkg::QUO_W-1] && ql[rmq_pkg::QUO_W-2:0] != '0)) begin
        quo = {1'b1, {(rmq_pkg::ELEM_W-1){1'b0}}};
      end else begin
        quo = rmq_pkg::elem_t'(-ql);
      end
    end else begin
      if (ovf_q[rmq_pkg::DIV_STAGES-1] || ql[rmq_pkg::QUO_W-1]) begin
        quo = {1'b0, {(rmq_pkg::ELEM_W-1){1'b1}}};
      end else begin
        quo = rmq_pkg::elem_t'(ql);
      end
    end
  end

endmodule

// ----- rtl/rmq_back.sv -----
// back end: square root, three dividers and the output register
module rmq_back (
  input  logic                         clk,
  input  logic                         rst,
  input  rmq_pkg::job_t                qdata,
  input  rmq_pkg::qstat_t              qstat,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [4*rmq_pkg::ELEM_W-1:0] m_tdata,
  output logic                         m_tuser
);

  logic                       adv;
  rmq_pkg::job_t              jq [rmq_pkg::SQRT_STAGES];
  logic                       vq [rmq_pkg::SQRT_STAGES];
  rmq_pkg::tag_t              tq [rmq_pkg::DIV_STAGES];
  logic                       vt [rmq_pkg::DIV_STAGES];
  rmq_pkg::job_t              jl;
  rmq_pkg::tag_t              tl;
  logic [rmq_pkg::ROOT_W-1:0] root;
  logic [rmq_pkg::ROOT_W:0]   half_sum;
  rmq_pkg::elem_t             d0, d1, d2, h, qx, qy, qz, qw;

  assign adv      = !m_tvalid || m_tready;
  assign pop      = adv && !qstat.empty;
  assign jl       = jq[rmq_pkg::SQRT_STAGES-1];
  assign tl       = tq[rmq_pkg::DIV_STAGES-1];
  assign half_sum = {1'b0, root} + 1'b1;

  rmq_sqrt u_sqrt (.clk(clk), .adv(adv), .rad(qdata.rad), .root(root));
  rmq_div  u_div0 (.clk(clk), .adv(adv), .num(jl.n0), .root(root), .quo(d0));
  rmq_div  u_div1 (.clk(clk), .adv(adv), .num(jl.n1), .root(root), .quo(d1));
  rmq_div  u_div2 (.clk(clk), .adv(adv), .num(jl.n2), .root(root), .quo(d2));

  always_comb begin
    h = rmq_pkg::elem_t'(tl.half);
    case (tl.path)
      rmq_pkg::PATH_X: begin
        qx = h;  qy = d0; qz = d1; qw = d2;
      end
      rmq_pkg::PATH_Y: begin
        qx = d0; qy = h;  qz = d1; qw = d2;
      end
      rmq_pkg::PATH_Z: begin
        qx = d0; qy = d1; qz = h;  qw = d2;
      end
      default: begin
        qx = d0; qy = d1; qz = d2; qw = h;
      end
    endcase
    if (tl.bad) begin
      qx = '0; qy = '0; qz = '0; qw = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < rmq_pkg::SQRT_STAGES; k++) begin
        vq[k] <= 1'b0;
      end
      for (int k = 0; k < rmq_pkg::DIV_STAGES; k++) begin
        vt[k] <= 1'b0;
      end
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vq[0] <= pop;
      for (int k = 1; k < rmq_pkg::SQRT_STAGES; k++) begin
        vq[k] <= vq[k-1];
      end
      vt[0] <= vq[rmq_pkg::SQRT_STAGES-1];
      for (int k = 1; k < rmq_pkg::DIV_STAGES; k++) begin
        vt[k] <= vt[k-1];
      end
      m_tvalid <= vt[rmq_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      jq[0] <= qdata;
      for (int k = 1; k < rmq_pkg::SQRT_STAGES; k++) begin
        jq[k] <= jq[k-1];
      end
      tq[0] <= '{path: jl.path, bad: jl.bad, half: half_sum[rmq_pkg::ROOT_W:1]};
      for (int k = 1; k < rmq_pkg::DIV_STAGES; k++) begin
        tq[k] <= tq[k-1];
      end
      m_tdata <= {qw, qz, qy, qx};
      m_tuser <= tl.bad;
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("bad result carries nonzero data");

  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(vt[rmq_pkg::DIV_STAGES-1]))
    else $error("output valid without a finished transaction");

  a_pop_enter: assert property (@(posedge clk) disable iff (rst)
    adv && !qstat.empty |=> vq[0])
    else $error("popped transaction lost at pipe entry");

endmodule

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
// top level of the rotation matrix to quaternion unit
// Takes one 3x3 Q2.14 rotation matrix per clock while not stalled and returns the
// quaternion (x, y, z, w) in Q2.14 with bad_input on tuser. Throughput is one
// matrix per cycle when the output is not stalled; a result passes through the
// 17-stage square root, the 17-stage dividers and the output register. A
// four-entry queue decouples the input side from the arithmetic pipeline, which
// stalls as a whole while a result waits on the output.
module rotation_matrix_to_quaternion_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22
  input  logic [9*rmq_pkg::ELEM_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // quat_x, quat_y, quat_z, quat_w
  output logic [4*rmq_pkg::ELEM_W-1:0] m_tdata,
  // bad_input
  output logic                         m_tuser
);

  rmq_pkg::qstat_t qstat;
  rmq_pkg::job_t   wjob, rjob;
  logic            push, pop;

  rmq_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .qstat    (qstat),
    .push     (push),
    .job      (wjob)
  );

  rmq_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wjob),
    .pop   (pop),
    .rdata (rjob),
    .qstat (qstat)
  );

  rmq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qdata    (rjob),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
